// ===== hw/rtl/encoder_speed_pid_drive_defines.svh =====
// Assertion macros shared by the RTL files.
// Every assertion samples on clk_i and is off while rst_ni is low.
`ifndef ENCODER_SPEED_PID_DRIVE_DEFINES_SVH
`define ENCODER_SPEED_PID_DRIVE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds.
`define ESPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never occurs.
`define ESPD_ASSERT_NEVER(lbl, cond, msg) \
  `ESPD_ASSERT(lbl, !(cond), msg)
`else
`define ESPD_ASSERT(lbl, prop, msg)
`define ESPD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/espd_pkg.sv =====
package espd_pkg;

  // Field and operand widths
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned MPLR_W  = 12;
  localparam int unsigned DRIVE_W = 14;
  localparam int unsigned CNT_W   = 5;

  // Serial unit step counts
  localparam logic [CNT_W-1:0] MUL_STEPS = 5'd12;
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd16;

  // Control-law constants
  localparam logic signed [DATA_W-1:0] DRIVE_PERIOD = 16'sd16000;
  localparam logic [MPLR_W-1:0]        SAMPLE_SCALE = 12'd15;
  localparam logic [DATA_W-1:0]        RATE_SCALE   = 16'd67;
  localparam logic [10:0]              INT_DIVISOR  = 11'd1000;

  // Register map (word index) and reset values
  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_D = 2'd1;
  localparam logic [1:0] REG_GAIN_I = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 8'd8;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 8'd10;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 8'd1;

  typedef enum logic {
    SER_MUL,
    SER_DIV
  } ser_op_e;

  // Request to the shared serial multiply/divide unit
  typedef struct packed {
    logic              start;
    ser_op_e           op;
    logic [DATA_W-1:0] a;
    logic [MPLR_W-1:0] b;
  } ser_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } ser_rsp_t;

endpackage

// ===== hw/rtl/espd_serial.sv =====
`include "encoder_speed_pid_drive_defines.svh"

// Bit-serial unit: a 16x12 multiply mod 2^16 (one multiplier bit per cycle)
// or an unsigned 16-bit divide by 1000 (one quotient bit per cycle).
module espd_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  espd_pkg::ser_req_t req_i,
  output espd_pkg::ser_rsp_t rsp_o
);
  import espd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  ser_op_e           op_q, op_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] sh_q, sh_d;
  logic [MPLR_W-1:0] mplr_q, mplr_d;
  logic [10:0]       trial;
  logic [10:0]       trial_sub;
  logic              qbit;

  // Start a run, or take one step of the multiply or of the restoring division
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    op_d      = op_q;
    acc_d     = acc_q;
    sh_d      = sh_q;
    mplr_d    = mplr_q;
    trial     = {acc_q[9:0], sh_q[DATA_W-1]};
    qbit      = (trial >= INT_DIVISOR);
    trial_sub = trial - INT_DIVISOR;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == SER_DIV) ? DIV_STEPS : MUL_STEPS;
      acc_d  = '0;
      sh_d   = req_i.a;
      mplr_d = req_i.b;
    end else if (busy_q) begin
      if (op_q == SER_DIV) begin
        acc_d = {6'b0, (qbit ? trial_sub[9:0] : trial[9:0])};
        sh_d  = {sh_q[DATA_W-2:0], qbit};
      end else begin
        if (mplr_q[0]) begin
          acc_d = acc_q + sh_q;
        end
        sh_d   = {sh_q[DATA_W-2:0], 1'b0};
        mplr_d = {1'b0, mplr_q[MPLR_W-1:1]};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= SER_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // Hold the datapath shift registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sh_q   <= sh_d;
    mplr_q <= mplr_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == SER_DIV) ? sh_q : acc_q;

  `ESPD_ASSERT_NEVER(a_no_restart, req_i.start && busy_q, "serial unit restarted while busy")
  `ESPD_ASSERT(a_rem_bound, busy_q && (op_q == SER_DIV) |-> acc_q < 16'd1000, "remainder out of range")
  `ESPD_ASSERT(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q, "done without a finished run")

endmodule

// ===== hw/rtl/encoder_speed_pid_drive.sv =====
// Encoder speed PID drive. Edge items (opcode 0) step the 16-bit position
// count up or down and give no result. Tick items (opcode 1) run one control
// step and give one result, computed on the shared bit-serial multiply/divide
// unit, which runs three 12-step multiplies and a 16-step division by 1000
// one after another. Input is taken only between control steps; a finished
// result waits in the output register while the next item is accepted, and a
// step stalls at its end while an earlier result is still unclaimed. Gains
// are written over the APB port at byte addresses 0 (proportional), 4
// (derivative) and 8 (integral).
`include "encoder_speed_pid_drive_defines.svh"

module encoder_speed_pid_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Item input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic                                 direction_up_i,
  input  logic signed [espd_pkg::DATA_W-1:0]   target_speed_i,
  // Result output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [espd_pkg::DRIVE_W-1:0]         drive_value_o,
  output logic signed [espd_pkg::DATA_W-1:0]   measured_speed_o,
  output logic signed [espd_pkg::DATA_W-1:0]   speed_error_o,
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import espd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_P     = 4'd2;
  localparam logic [3:0] S_I     = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_D     = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [GAIN_W-1:0]  gain_p_q, gain_d_q, gain_i_q;
  logic [DATA_W-1:0]  pos_q, last_pos_q, last_err_q, acc_q;
  logic [DATA_W-1:0]  speed_q, target_q, err_q, diff_q, sum_q, d_q;
  logic               neg_q;
  logic               out_valid_q;
  logic [DRIVE_W-1:0] drive_q;
  logic [DATA_W-1:0]  ospeed_q, oerr_q;

  logic               in_acc;
  logic               cfg_we;
  logic               out_load;
  logic [DATA_W-1:0]  err_calc;
  logic [DATA_W-1:0]  res_mag;
  logic [DATA_W-1:0]  quo_signed;
  logic [DATA_W-1:0]  d_scaled;
  logic [DATA_W-1:0]  acc_sum;
  logic [DATA_W-1:0]  acc_clamped;
  logic [MPLR_W-1:0]  ki_scaled;
  ser_req_t           ser_req;
  ser_rsp_t           ser_rsp;

  espd_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ser_req),
    .rsp_o  (ser_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Error against the speed magnitude: add a negative speed, subtract a positive one
  assign err_calc   = speed_q[DATA_W-1] ? (target_q + speed_q) : (target_q - speed_q);
  assign res_mag    = ser_rsp.result[DATA_W-1] ? (16'd0 - ser_rsp.result) : ser_rsp.result;
  assign quo_signed = neg_q ? (16'd0 - ser_rsp.result) : ser_rsp.result;
  assign d_scaled   = DATA_W'(ser_rsp.result * RATE_SCALE);
  assign ki_scaled  = MPLR_W'({4'b0, gain_i_q} * SAMPLE_SCALE);
  assign acc_sum    = acc_q + sum_q + d_q;

  // Clamp the accumulator to the drive period
  always_comb begin
    acc_clamped = acc_q;
    if ($signed(acc_q) >= DRIVE_PERIOD) begin
      acc_clamped = DRIVE_PERIOD - 16'sd1;
    end else if ($signed(acc_q) <= 16'sd0) begin
      acc_clamped = 16'd1;
    end
  end

  // Sequence the control step and issue serial operations
  always_comb begin
    state_d = state_q;
    ser_req = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && opcode_i) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        ser_req.start = 1'b1;
        ser_req.op    = SER_MUL;
        ser_req.a     = err_calc;
        ser_req.b     = {4'b0, gain_p_q};
        state_d       = S_P;
      end
      S_P: begin
        if (ser_rsp.done) begin
          ser_req.start = 1'b1;
          ser_req.op    = SER_MUL;
          ser_req.a     = err_q;
          ser_req.b     = ki_scaled;
          state_d       = S_I;
        end
      end
      S_I: begin
        if (ser_rsp.done) begin
          ser_req.start = 1'b1;
          ser_req.op    = SER_DIV;
          ser_req.a     = res_mag;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (ser_rsp.done) begin
          ser_req.start = 1'b1;
          ser_req.op    = SER_MUL;
          ser_req.a     = diff_q;
          ser_req.b     = {4'b0, gain_d_q};
          state_d       = S_D;
        end
      end
      S_D: begin
        if (ser_rsp.done) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, block state and gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_p_q    <= GAIN_P_RST;
      gain_d_q    <= GAIN_D_RST;
      gain_i_q    <= GAIN_I_RST;
      pos_q       <= '0;
      last_pos_q  <= '0;
      last_err_q  <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
          REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
          REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (!opcode_i) begin
          pos_q <= direction_up_i ? (pos_q + 16'd1) : (pos_q - 16'd1);
        end else begin
          last_pos_q <= pos_q;
        end
      end
      if (state_q == S_SUM) begin
        acc_q <= acc_sum;
      end
      if (state_q == S_CLAMP) begin
        acc_q      <= acc_clamped;
        last_err_q <= err_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Step payload and output register
  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i) begin
      speed_q  <= pos_q - last_pos_q;
      target_q <= target_speed_i;
    end
    if (state_q == S_ERR) begin
      err_q <= err_calc;
    end
    if ((state_q == S_P) && ser_rsp.done) begin
      sum_q  <= ser_rsp.result;
      diff_q <= err_q - last_err_q;
    end
    if ((state_q == S_I) && ser_rsp.done) begin
      neg_q <= ser_rsp.result[DATA_W-1];
    end
    if ((state_q == S_DIV) && ser_rsp.done) begin
      sum_q <= sum_q + quo_signed;
    end
    if ((state_q == S_D) && ser_rsp.done) begin
      d_q <= d_scaled;
    end
    if (out_load) begin
      drive_q  <= acc_q[DRIVE_W-1:0];
      ospeed_q <= speed_q;
      oerr_q   <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_value_o    = drive_q;
  assign measured_speed_o = ospeed_q;
  assign speed_error_o    = oerr_q;

  // APB register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_GAIN_P: prdata = {24'b0, gain_p_q};
      REG_GAIN_D: prdata = {24'b0, gain_d_q};
      REG_GAIN_I: prdata = {24'b0, gain_i_q};
      default:    prdata = '0;
    endcase
  end

  `ESPD_ASSERT(a_tick_starts, in_acc && opcode_i |=> state_q == S_ERR, "tick did not start a step")
  `ESPD_ASSERT(a_acc_clamped,
               state_q == S_OUT |-> ($signed(acc_q) > 16'sd0) && ($signed(acc_q) < DRIVE_PERIOD),
               "drive outside clamp range")
  `ESPD_ASSERT(a_done_waited,
               ser_rsp.done |-> (state_q == S_P) || (state_q == S_I) ||
                                (state_q == S_DIV) || (state_q == S_D),
               "serial result with no waiting state")

endmodule
